>>> hdl/nmsm_pkg.sv
`default_nettype none
package nmsm_pkg;

	localparam int MAG_W  = 31;
	localparam int WORD_W = 32;
	localparam int CFG_W  = 5;
	localparam int ADDR_W = 3;

	localparam logic [CFG_W-1:0] UNIT_SIZE_RST  = CFG_W'(4);
	localparam logic [CFG_W-1:0] KEEP_COUNT_RST = CFG_W'(2);

	typedef enum logic [0:0] {
		REG_UNIT_SIZE  = 1'b0,
		REG_KEEP_COUNT = 1'b1
	} reg_idx_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;  // a weight is taken this cycle
		logic shift;   // chain moves one cell toward the output
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/nm_sparsity_mask_generator_unit.sv
`default_nettype none
// N:M structured sparsity mask generator. Float weights arrive one per cycle and
// are collected in a chain of MAX_UNIT cells; each cell keeps one magnitude (sign
// bit dropped) and a count of the unit's elements that outrank it, updated by a
// broadcast compare as every weight enters, ties going to the earlier element.
// While a unit fills, one weight is taken each cycle. The weight that completes a
// unit (unit_size reached, or array_end set) starts an emission: the chain shifts
// toward the output register and sends one keep bit per cycle unless out_stall
// holds it, oldest element first, and input is stalled. unit_size is checked as
// each weight is taken, keep_count as each keep bit forms. The user must see that
// configuration is written through the APB port while idle; not enforced here.
module nm_sparsity_mask_generator_unit #(
	parameter int MAX_UNIT = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nmsm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [nmsm_pkg::WORD_W-1:0]   pwdata,
	output logic [nmsm_pkg::WORD_W-1:0]        prdata,
	output logic                               pready,
	// weight input
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [nmsm_pkg::WORD_W-1:0]   weight_bits,
	input  wire logic                          array_end,
	// mask output
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               keep_bit,
	output logic                               unit_last,
	output logic                               array_last
);
	import nmsm_pkg::*;

	localparam int CNT_W = $clog2(MAX_UNIT + 1);

	logic [CFG_W-1:0]  unit_size_q;
	logic [CFG_W-1:0]  keep_count_q;
	logic [CNT_W-1:0]  fill_q;
	logic              emitting_q;
	logic              arr_end_q;
	logic              out_valid_q;
	logic              keep_bit_q;
	logic              unit_last_q;
	logic              array_last_q;

	logic              cfg_wr;
	logic              in_fire;
	logic              emit_fire;
	logic              unit_close;
	logic [31:0]       eff_unit;
	logic [MAG_W-1:0]  new_mag;
	logic [CNT_W-1:0]  new_ahead;
	cell_ctrl_t        ctrl;

	logic [MAX_UNIT:0]   cell_valid;
	logic [MAG_W-1:0]    cell_mag   [MAX_UNIT+1];
	logic [CNT_W-1:0]    cell_ahead [MAX_UNIT+1];
	logic [MAX_UNIT-1:0] cell_ge;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_size_q  <= UNIT_SIZE_RST;
			keep_count_q <= KEEP_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_UNIT_SIZE:  unit_size_q  <= pwdata[CFG_W-1:0];
				REG_KEEP_COUNT: keep_count_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_UNIT_SIZE:  prdata = {{(WORD_W-CFG_W){1'b0}}, unit_size_q};
			REG_KEEP_COUNT: prdata = {{(WORD_W-CFG_W){1'b0}}, keep_count_q};
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		if (unit_size_q == '0) begin
			eff_unit = 32'd1;
		end else if (32'(unit_size_q) > 32'(MAX_UNIT)) begin
			eff_unit = 32'(MAX_UNIT);
		end else begin
			eff_unit = 32'(unit_size_q);
		end
	end

	// ---------------- cell chain ----------------
	assign in_stall   = emitting_q;
	assign in_fire    = in_valid && !in_stall;
	assign emit_fire  = emitting_q && (!out_valid_q || !out_stall);
	assign unit_close = array_end || ((32'(fill_q) + 32'd1) >= eff_unit);
	assign new_mag    = weight_bits[MAG_W-1:0];
	assign new_ahead  = CNT_W'($countones(cell_ge));

	assign ctrl.insert = in_fire;
	assign ctrl.shift  = emit_fire;

	assign cell_valid[MAX_UNIT] = 1'b0;
	assign cell_mag[MAX_UNIT]   = '0;
	assign cell_ahead[MAX_UNIT] = '0;

	for (genvar i = 0; i < MAX_UNIT; i++) begin : g_cell
		logic prev_v;
		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end

		nmsm_cell #(
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_mag    (new_mag),
			.new_ahead  (new_ahead),
			.prev_valid (prev_v),
			.next_valid (cell_valid[i+1]),
			.next_mag   (cell_mag[i+1]),
			.next_ahead (cell_ahead[i+1]),
			.valid      (cell_valid[i]),
			.mag        (cell_mag[i]),
			.ahead      (cell_ahead[i]),
			.ge         (cell_ge[i])
		);
	end

	// ---------------- control and output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			emitting_q   <= 1'b0;
			arr_end_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			keep_bit_q   <= 1'b0;
			unit_last_q  <= 1'b0;
			array_last_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (unit_close) begin
					fill_q     <= '0;
					emitting_q <= 1'b1;
					arr_end_q  <= array_end;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end

			if (emit_fire) begin
				out_valid_q  <= 1'b1;
				keep_bit_q   <= 32'(cell_ahead[0]) < 32'(keep_count_q);
				unit_last_q  <= !cell_valid[1];
				array_last_q <= !cell_valid[1] && arr_end_q;
				if (!cell_valid[1]) begin
					emitting_q <= 1'b0;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign keep_bit   = keep_bit_q;
	assign unit_last  = unit_last_q;
	assign array_last = array_last_q;

	// ---------------- assertions ----------------
	a_fill_matches_chain: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) == 32'($countones(cell_valid)) || emitting_q)
		else $error("fill count disagrees with occupied cells");

	a_emit_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		emitting_q |-> cell_valid[0])
		else $error("emission with an empty chain");

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && !cell_valid[1]) |=> (!emitting_q && !cell_valid[0]))
		else $error("chain not drained after final mask bit");

	a_array_last_closes_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && array_last_q) |-> unit_last_q)
		else $error("array end flagged inside a unit");

endmodule
`default_nettype wire

>>> hdl/nmsm_cell.sv
`default_nettype none
module nmsm_cell #(
	parameter int CNT_W = 5
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire nmsm_pkg::cell_ctrl_t        ctrl,
	input  wire logic [nmsm_pkg::MAG_W-1:0]  new_mag,
	input  wire logic [CNT_W-1:0]            new_ahead,
	input  wire logic                        prev_valid,
	input  wire logic                        next_valid,
	input  wire logic [nmsm_pkg::MAG_W-1:0]  next_mag,
	input  wire logic [CNT_W-1:0]            next_ahead,
	output logic                             valid,
	output logic [nmsm_pkg::MAG_W-1:0]       mag,
	output logic [CNT_W-1:0]                 ahead,
	output logic                             ge
);
	import nmsm_pkg::*;

	logic                 valid_q;
	logic [MAG_W-1:0]     mag_q;
	logic [CNT_W-1:0]     ahead_q;
	logic                 load_here;

	// first empty cell of the chain takes the new weight
	assign load_here = ctrl.insert && prev_valid && !valid_q;
	// held element ranks ahead of the newcomer on ties (it came earlier)
	assign ge        = valid_q && (mag_q >= new_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (load_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			mag_q   <= next_mag;
			ahead_q <= next_ahead;
		end else if (load_here) begin
			mag_q   <= new_mag;
			ahead_q <= new_ahead;
		end else if (ctrl.insert && valid_q && (new_mag > mag_q)) begin
			ahead_q <= ahead_q + CNT_W'(1);
		end
	end

	assign valid = valid_q;
	assign mag   = mag_q;
	assign ahead = ahead_q;

endmodule
`default_nettype wire

>>> verif/tb_nm_sparsity_mask_generator_unit.sv
`timescale 1ns / 1ps

module tb_nm_sparsity_mask_generator_unit;
	import nmsm_pkg::*;

	localparam int MAX_UNIT  = 16;
	localparam int SETTLE    = 40;    // cycles after the last mask bit before a register write
	localparam int HOLD_OFF  = 250;   // long receiver stall
	localparam int WDOG_MAX  = 3000;  // cycles with no transaction on either side
	localparam int RAND_ITEMS = 120;

	typedef enum logic [0:0] {
		ROW_WEIGHT = 1'b0,
		ROW_CFG    = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    reg_sel;
		logic [31:0] reg_val;
		logic [31:0] weight;
		logic        closes;    // array_end
		logic [4:0]  exp_n;     // 0: no typed mask for this row
		logic [15:0] exp_mask;
	} stim_row_t;

	typedef struct packed {
		logic keep;
		logic unit_end;
		logic arr_end;
	} mask_bit_t;

	localparam int DIR_ROWS = 31;
	// default unit 4, keep 2 after reset
	localparam stim_row_t DIRECTED [0:DIR_ROWS-1] = '{
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h3F800000, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'hBF800000, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h7FFFFFFF, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h00000000, 1'b0, 5'd4, 16'h0005},
		// -0 ties +0, earlier wins; partial unit closed by array_end
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h80000000, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h00000000, 1'b1, 5'd2, 16'h0003},
		// upper bits ignored: keep_count becomes 0
		'{ROW_CFG,    REG_KEEP_COUNT, 32'hFFFFFFE0, 32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'hFFFFFFFF, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h12345678, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h00000001, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h7F800000, 1'b0, 5'd4, 16'h0000},
		'{ROW_CFG,    REG_UNIT_SIZE,  32'h1,        32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_CFG,    REG_KEEP_COUNT, 32'h1,        32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'hFFFFFFFF, 1'b1, 5'd1, 16'h0001},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h55555555, 1'b0, 5'd1, 16'h0001},
		// unit_size 0 acts as 1, keep above unit keeps all
		'{ROW_CFG,    REG_UNIT_SIZE,  32'h20,       32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_CFG,    REG_KEEP_COUNT, 32'h1F,       32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'hAAAAAAAA, 1'b0, 5'd1, 16'h0001},
		// unit_size 31 acts as 16
		'{ROW_CFG,    REG_UNIT_SIZE,  32'h1F,       32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_CFG,    REG_KEEP_COUNT, 32'h1,        32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h3F800000, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h40400000, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'hC0000000, 1'b1, 5'd3, 16'h0002},
		// unit size lowered while three elements are buffered
		'{ROW_CFG,    REG_UNIT_SIZE,  32'h8,        32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h00000010, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h80000020, 1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h00000020, 1'b0, 5'd0, 16'h0},
		'{ROW_CFG,    REG_UNIT_SIZE,  32'h2,        32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_WEIGHT, REG_UNIT_SIZE,  32'h0,        32'h00000020, 1'b0, 5'd4, 16'h0002},
		'{ROW_CFG,    REG_UNIT_SIZE,  32'h4,        32'h0,        1'b0, 5'd0, 16'h0},
		'{ROW_CFG,    REG_KEEP_COUNT, 32'h2,        32'h0,        1'b0, 5'd0, 16'h0}
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [WORD_W-1:0]   pwdata;
	logic [WORD_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [WORD_W-1:0]   weight_bits;
	logic                array_end;
	logic                out_valid;
	logic                out_stall;
	logic                keep_bit;
	logic                unit_last;
	logic                array_last;

	// shadow of the block
	logic [4:0]          unit_cfg;
	logic [4:0]          keep_cfg;
	logic [MAG_W-1:0]    mag_buf [MAX_UNIT];
	int                  fill;
	int                  closed_n;
	logic [15:0]         closed_mask;

	mask_bit_t           mask_queue [$];
	int                  errors;
	int                  idle_cycles;
	bit                  quiet;
	bit                  hold_req;

	nm_sparsity_mask_generator_unit #(.MAX_UNIT(MAX_UNIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.weight_bits(weight_bits),
		.array_end(array_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.keep_bit(keep_bit),
		.unit_last(unit_last),
		.array_last(array_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// buffer one magnitude; rank and queue the mask when the unit closes
	task automatic rank_weight(input logic [31:0] w, input logic closes);
		int eff;
		int ahead;
		mask_bit_t mb;
		closed_n = 0;
		closed_mask = '0;
		if (fill < MAX_UNIT) begin
			mag_buf[fill] = w[MAG_W-1:0];
			fill++;
		end
		eff = (unit_cfg == 0) ? 1 : (unit_cfg > MAX_UNIT) ? MAX_UNIT : int'(unit_cfg);
		if (fill < eff && !closes)
			return;
		for (int i = 0; i < fill; i++) begin
			ahead = 0;
			for (int j = 0; j < fill; j++)
				if (mag_buf[j] > mag_buf[i] || (mag_buf[j] == mag_buf[i] && j < i))
					ahead++;
			mb.keep = (ahead < int'(keep_cfg));
			mb.unit_end = (i == fill - 1);
			mb.arr_end = (i == fill - 1) && closes;
			closed_mask[i] = mb.keep;
			mask_queue.insert(mask_queue.size(), mb);
		end
		closed_n = fill;
		fill = 0;
	endtask

	// input prediction first, then output check, both on the same edge
	always @(posedge clk) begin
		mask_bit_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				rank_weight(weight_bits, array_end);
			if (out_valid && !out_stall) begin
				if (mask_queue.size() == 0) begin
					flag($sformatf("unexpected mask bit keep=%0b unit_last=%0b array_last=%0b",
						keep_bit, unit_last, array_last));
				end else begin
					want = mask_queue.pop_front();
					if (keep_bit !== want.keep || unit_last !== want.unit_end ||
							array_last !== want.arr_end)
						flag($sformatf("keep/unit_last/array_last exp %0b%0b%0b got %0b%0b%0b",
							want.keep, want.unit_end, want.arr_end,
							keep_bit, unit_last, array_last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_MAX) begin
			$display("[nm_sparsity_mask_generator_unit] ERROR");
			$finish;
		end
	end

	// mask receiver: random stalls, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 28);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_weight(input logic [31:0] w, input logic closes);
		if (!quiet && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < 28);
		end
		in_valid <= 1'b1;
		weight_bits <= w;
		array_end <= closes;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (mask_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_UNIT_SIZE:  unit_cfg = val[4:0];
			REG_KEEP_COUNT: keep_cfg = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_weight();
		logic [31:0] w;
		case ($urandom_range(3))
			1: begin
				case ($urandom_range(4))
					0: w = 32'h00000000;
					1: w = 32'h3F800000;
					2: w = 32'h7FFFFFFF;
					3: w = 32'h7F800000;
					default: w = 32'h00000001;
				endcase
				w[31] = 1'($urandom_range(1));
			end
			// small magnitudes: plenty of ties
			2: w = {1'($urandom_range(1)), 27'd0, 4'($urandom_range(15))};
			default: w = $urandom;
		endcase
		return w;
	endfunction

	initial begin
		int sent;
		int phase;
		int len;
		logic [4:0] u;
		logic [4:0] k;
		logic closes;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		weight_bits = '0;
		array_end = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		errors = 0;
		idle_cycles = 0;
		fill = 0;
		closed_n = 0;
		closed_mask = '0;
		unit_cfg = UNIT_SIZE_RST;
		keep_cfg = KEEP_COUNT_RST;
		sent = 0;
		phase = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				wait_idle();
				apb_write(DIRECTED[r].reg_sel, DIRECTED[r].reg_val);
			end else begin
				send_weight(DIRECTED[r].weight, DIRECTED[r].closes);
				if (DIRECTED[r].exp_n != 0 && (closed_n != int'(DIRECTED[r].exp_n) ||
						closed_mask != DIRECTED[r].exp_mask))
					flag($sformatf("row %0d closed %0d elements mask %h, table %0d mask %h",
						r, closed_n, closed_mask, DIRECTED[r].exp_n, DIRECTED[r].exp_mask));
			end
		end

		while (sent < RAND_ITEMS) begin
			wait_idle();
			case (phase)
				0: begin u = 5'd16; k = 5'd8; end
				1: begin u = 5'd3; k = 5'd1; end
				2: begin u = 5'd31; k = 5'd16; end
				default: begin
					case ($urandom_range(7))
						0: u = 5'd0;
						1: u = 5'd1;
						2: u = 5'($urandom_range(9, 31));
						default: u = 5'($urandom_range(2, 6));
					endcase
					case ($urandom_range(4))
						0: k = 5'd0;
						1: k = 5'd31;
						default: k = 5'($urandom_range(1, 6));
					endcase
				end
			endcase
			// sometimes only one register changes; order varies
			if ($urandom_range(1)) begin
				if (phase < 3 || $urandom_range(3) != 0)
					apb_write(REG_UNIT_SIZE, {27'($urandom), u});
				if (phase < 3 || $urandom_range(3) != 0)
					apb_write(REG_KEEP_COUNT, {27'($urandom), k});
			end else begin
				if (phase < 3 || $urandom_range(3) != 0)
					apb_write(REG_KEEP_COUNT, {27'($urandom), k});
				if (phase < 3 || $urandom_range(3) != 0)
					apb_write(REG_UNIT_SIZE, {27'($urandom), u});
			end

			quiet = (phase == 3 || phase == 4);
			if (phase == 1)
				hold_req = 1'b1;
			len = (phase == 1) ? 30 : $urandom_range(8, 20);
			for (int i = 0; i < len; i++) begin
				if (phase == 5 && i == len / 2) begin
					in_valid <= 1'b0;
					while (mask_queue.size() != 0)
						@(negedge clk);
					@(negedge clk);
				end
				closes = ($urandom_range(9) == 0) || (i == len - 1 && $urandom_range(1));
				send_weight(pick_weight(), closes);
				sent++;
			end
			quiet = 1'b0;
			phase++;
		end

		in_valid <= 1'b0;
		while (mask_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);

		if (errors == 0 && mask_queue.size() == 0)
			$display("[nm_sparsity_mask_generator_unit] OK");
		else
			$display("[nm_sparsity_mask_generator_unit] ERROR");
		$finish;
	end

endmodule
